/* sv/table_driven_block_permuter_top_macros.svh */
// Assertion macros shared by the checker of the block permuter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef TABLE_DRIVEN_BLOCK_PERMUTER_TOP_MACROS_SVH
`define TABLE_DRIVEN_BLOCK_PERMUTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("block permuter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TDBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("block permuter assertion failed");

`endif

/* sv/tdbp_pkg.sv */
// Shared constants and types of the table driven block permuter.
// Depends on nothing; imported by tdbp_out_fifo, the top level and the checker.
package tdbp_pkg;

  localparam int FRAME       = 1008;
  localparam int SAMPLE_BITS = 32;
  localparam int LANES       = 4;
  localparam int ROWS        = FRAME / LANES;
  localparam int ROW_W       = 8;
  localparam int ENTRY_W     = 10;
  localparam int FIELD_W     = 32;
  localparam int STORE_W     = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int SADDR_W     = ROW_W + 1;

  // Stream payload layout.
  localparam int IDX_LSB     = LANES * FIELD_W;
  localparam int ENTRY_LSB   = IDX_LSB + ENTRY_W;
  localparam int S_TDATA_W   = ((ENTRY_LSB + ENTRY_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = LANES * FIELD_W;

  // Result queue.
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  // Item kinds carried in tuser.
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_TABLE = 1'b1;

  typedef logic [M_TDATA_W-1:0]  result_t;
  typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;

endpackage

/* sv/tdbp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing. A read of the address being written returns the old data.
module tdbp_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tdbp_out_fifo.sv */
// Small result queue that decouples the permuter pipeline from the output stream.
// Depends on tdbp_pkg for its depth and payload type.
module tdbp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tdbp_pkg::result_t push_data_i,
  output tdbp_pkg::fifo_cnt_t count_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output tdbp_pkg::result_t pop_data_o
);
  import tdbp_pkg::*;

  result_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_q, wr_d;
  logic [FIFO_PTR_W-1:0]   rd_q, rd_d;
  fifo_cnt_t               cnt_q, cnt_d;
  logic                    pop;

  assign pop = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign count_o     = cnt_q;

endmodule

/* sv/table_driven_block_permuter_top.sv */
// Top level of the table driven block permuter (ping-pong frame reordering).
// Depends on tdbp_pkg, tdbp_ram and tdbp_out_fifo.
//
// The block reorders frames of FRAME samples that arrive four per item. It takes
// one item per clock while input ready is high: a data item (tuser low) writes
// its four samples in linear order into the current half of a ping-pong sample
// store and, in the same pass, reads four samples of the previous frame from the
// other half at the positions held in the permutation table; a table item (tuser
// high) writes one table entry and gives no result. The halves swap after the
// last row of each frame, and the first FRAME/4 data items after reset give no
// result. A result passes through the table bank read, the sample bank read and
// a four-entry result queue in front of the output. Input ready drops only when
// the queue together with the items still in the two read stages would overflow
// it, so a stalled output fills the queue before the input side is held. There
// is no clearing pass after reset: the table must be loaded before data that
// depends on it is sent, and entries never written read as arbitrary values.
module table_driven_block_permuter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit first: sample0, sample1, sample2, sample3,
  // table_index, table_entry, zero fill.
  input  logic [tdbp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: func (0 = data item, 1 = table item).
  input  logic                             s_axis_tuser,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit first: out0, out1, out2, out3.
  output logic [tdbp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import tdbp_pkg::*;

  // Input handshake and item decode.
  logic               s_hs;
  logic               data_acc;
  logic               tab_acc;
  logic [ENTRY_W-1:0] tab_idx;
  logic [ENTRY_W-1:0] tab_entry;
  logic               tab_we;

  assign s_hs      = s_axis_tvalid && s_axis_tready;
  assign data_acc  = s_hs && (s_axis_tuser == FUNC_DATA);
  assign tab_acc   = s_hs && (s_axis_tuser == FUNC_TABLE);
  assign tab_idx   = s_axis_tdata[IDX_LSB +: ENTRY_W];
  assign tab_entry = s_axis_tdata[ENTRY_LSB +: ENTRY_W];
  // Writes to slots at or beyond the frame length are dropped.
  assign tab_we    = tab_acc && ({1'b0, tab_idx} < (ENTRY_W + 1)'(FRAME));

  // Frame bookkeeping.
  logic [ROW_W-1:0] pos_q, pos_d;
  logic             half_q, half_d;
  logic [ROW_W-1:0] start_q, start_d;
  logic             run_q, run_d;

  always_comb begin
    pos_d   = pos_q;
    half_d  = half_q;
    start_d = start_q;
    run_d   = run_q;
    if (data_acc) begin
      if (pos_q == ROW_W'(ROWS - 1)) begin
        pos_d  = '0;
        half_d = ~half_q;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      // Output starts once the other half holds a complete frame.
      if (!run_q) begin
        if (start_q == ROW_W'(ROWS - 1)) begin
          run_d = 1'b1;
        end else begin
          start_d = start_q + 1'b1;
        end
      end
    end
  end

  // Read pipeline: stage 1 waits on the table banks, stage 2 on the sample banks.
  logic               s1_vld_q;
  logic               s1_half_q;
  logic               s2_vld_q;
  logic [1:0]         s2_bank_q [LANES];
  logic               s2_zero_q [LANES];

  logic [ENTRY_W-1:0] entry     [LANES];
  logic [STORE_W-1:0] sram_rd   [LANES][LANES];
  result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      half_q   <= 1'b0;
      start_q  <= '0;
      run_q    <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      half_q   <= half_d;
      start_q  <= start_d;
      run_q    <= run_d;
      s1_vld_q <= data_acc && run_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  // The read half is the one not being written by the accepted item.
  always_ff @(posedge clk_i) begin
    s1_half_q <= ~half_q;
  end

  genvar lane, bank;
  generate
    for (lane = 0; lane < LANES; lane++) begin : g_lane
      // Table bank for this lane holds slots lane, lane+4, lane+8, ...
      tdbp_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (ROW_W)
      ) u_tab_ram (
        .clk_i   (clk_i),
        .we_i    (tab_we && (tab_idx[1:0] == 2'(lane))),
        .waddr_i (tab_idx[ENTRY_W-1:2]),
        .wdata_i (tab_entry),
        .raddr_i (pos_q),
        .rdata_o (entry[lane])
      );

      // Each output lane owns a copy of all four sample banks, so the four
      // lanes can read any four positions in the same cycle.
      for (bank = 0; bank < LANES; bank++) begin : g_bank
        tdbp_ram #(
          .DATA_W (STORE_W),
          .ADDR_W (SADDR_W)
        ) u_smp_ram (
          .clk_i   (clk_i),
          .we_i    (data_acc),
          .waddr_i ({half_q, pos_q}),
          .wdata_i (s_axis_tdata[bank*FIELD_W +: STORE_W]),
          .raddr_i ({s1_half_q, entry[lane][ENTRY_W-1:2]}),
          .rdata_o (sram_rd[lane][bank])
        );
      end

      always_ff @(posedge clk_i) begin
        s2_bank_q[lane] <= entry[lane][1:0];
        // A source row past the frame names no stored sample.
        s2_zero_q[lane] <= ({1'b0, entry[lane][ENTRY_W-1:2]} >= (ROW_W + 1)'(ROWS));
      end

      assign result[lane*FIELD_W +: FIELD_W] =
        s2_zero_q[lane] ? '0 : FIELD_W'(sram_rd[lane][s2_bank_q[lane]]);
    end
  endgenerate

  // Result queue and flow control.
  fifo_cnt_t         fifo_cnt;
  logic [FIFO_CNT_W:0] occ;

  tdbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_vld_q),
    .push_data_i (result),
    .count_o     (fifo_cnt),
    .pop_valid_o (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .pop_data_o  (m_axis_tdata)
  );

  // Queue entries plus results still in the read stages must leave room for one more.
  assign occ = {1'b0, fifo_cnt} + (FIFO_CNT_W + 1)'(s1_vld_q)
             + (FIFO_CNT_W + 1)'(s2_vld_q);
  assign s_axis_tready = (occ < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

endmodule

/* sv/tdbp_checker.sv */
// Port-level checker for the table driven block permuter, bound to the top level.
// Depends on tdbp_pkg and table_driven_block_permuter_top_macros.svh.
`include "table_driven_block_permuter_top_macros.svh"

module tdbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [tdbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tdbp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import tdbp_pkg::*;

  logic [31:0] data_cnt_q;
  logic [31:0] out_cnt_q;
  logic        data_hs;
  logic        out_hs;
  logic        s_tdata_seen;

  assign data_hs      = s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_DATA);
  assign out_hs       = m_axis_tvalid && m_axis_tready;
  assign s_tdata_seen = ^s_axis_tdata || 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_cnt_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (data_hs && s_tdata_seen) begin
        data_cnt_q <= data_cnt_q + 1'b1;
      end
      if (out_hs) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end
    end
  end

  // A result waiting on the output stays offered with the same payload.
  `TDBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `TDBP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // Every delivered result is backed by a data item past the startup frame.
  `TDBP_ASSERT_IMPL(a_startup, clk_i, rst_ni, out_hs, data_cnt_q >= out_cnt_q + 32'(ROWS) + 32'd1)
  // No result is ever offered before a full frame of data items has come in.
  `TDBP_ASSERT_IMPL(a_no_early, clk_i, rst_ni, data_cnt_q < 32'(ROWS) + 32'd1, !m_axis_tvalid)

endmodule

bind table_driven_block_permuter_top tdbp_checker u_tdbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
